/* rtl/core/cpvf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpvf_pkg
// Shared types, constants and fixed-point helpers for the cabin view frame.
// ----------------------------------------------------------------------------
package cpvf_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int SIN_STEPS      = 6;

  // Q30 unit
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  // quarter-wave sine polynomial, odd terms A1..A9 in Q30
  localparam logic signed [31:0] SIN_COEF [5] = '{
    32'sd1686629713, -32'sd693598668, 32'sd85569306, -32'sd5026995, 32'sd172273
  };

  // data carried by one sine cell
  typedef struct packed {
    logic [30:0]        x;
    logic [30:0]        x2;
    logic signed [31:0] p;
    logic               neg;
  } sin_lane_t;

  // positions carried beside the sine lanes
  typedef struct packed {
    logic signed [32:0] dx0;
    logic signed [32:0] dz0;
    logic signed [33:0] dy;
    logic [16:0]        reach;
  } side_t;

  // product of a and a Q30 value, rounded to nearest, halves away from zero
  function automatic logic signed [35:0] mul_q30(input logic signed [33:0] a,
                                                 input logic signed [31:0] b);
    logic        neg;
    logic [33:0] ua;
    logic [31:0] ub;
    logic [65:0] prod;
    logic [35:0] m;
    neg  = a[33] ^ b[31];
    ua   = a[33] ? 34'(-a) : 34'(a);
    ub   = b[31] ? 32'(-b) : 32'(b);
    prod = 66'(ua) * 66'(ub) + 66'(1) * (66'(1) << 29);
    m    = prod[65:30];
    return neg ? 36'(-$signed(m)) : $signed(m);
  endfunction

  // clamp to the signed 32-bit range
  function automatic logic [31:0] sat32(input logic signed [36:0] v);
    if (v > 37'sd2147483647)       return 32'h7FFF_FFFF;
    else if (v < -37'sd2147483648) return 32'h8000_0000;
    else                           return v[31:0];
  endfunction

endpackage

/* rtl/core/cpvf_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpvf channel interfaces
// Valid/ready channels for the jetway/viewer input and the relative result.
// ----------------------------------------------------------------------------
interface cpvf_in_if #(parameter int ANGLE_BITS = 16);
  logic                    valid;
  logic                    ready;
  logic signed [31:0]      jetway_x;
  logic signed [31:0]      jetway_y;
  logic signed [31:0]      jetway_z;
  logic [ANGLE_BITS-1:0]   jetway_rotation;
  logic [ANGLE_BITS-1:0]   stand_heading;
  logic [15:0]             tunnel_extent;
  logic [15:0]             cabin_offset;
  logic signed [15:0]      cabin_height;
  logic signed [31:0]      eye_x;
  logic signed [31:0]      eye_y;
  logic signed [31:0]      eye_z;
  logic [ANGLE_BITS-1:0]   eye_heading;

  modport source (output valid, jetway_x, jetway_y, jetway_z, jetway_rotation,
                  stand_heading, tunnel_extent, cabin_offset, cabin_height,
                  eye_x, eye_y, eye_z, eye_heading, input ready);
  modport sink (input valid, jetway_x, jetway_y, jetway_z, jetway_rotation,
                stand_heading, tunnel_extent, cabin_offset, cabin_height,
                eye_x, eye_y, eye_z, eye_heading, output ready);
endinterface

interface cpvf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] rel_right;
  logic signed [31:0] rel_up;
  logic signed [31:0] rel_back;

  modport source (output valid, rel_right, rel_up, rel_back, input ready);
  modport sink (input valid, rel_right, rel_up, rel_back, output ready);
endinterface

/* rtl/core/cpvf_sin_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpvf_sin_cell
// One step of the quarter-wave sine polynomial: one Q30 multiply, with the coefficient add in the Horner steps.
// ----------------------------------------------------------------------------
module cpvf_sin_cell #(
  parameter int STEP = 0
) (
  input  logic                clk,
  input  logic                en,
  input  cpvf_pkg::sin_lane_t d,
  output cpvf_pkg::sin_lane_t q_r
);
  import cpvf_pkg::*;

  // coefficient added by a Horner step, kept in range for the other steps
  localparam int COEF_IDX = (STEP >= 1 && STEP <= 4) ? 4 - STEP : 0;

  sin_lane_t           q_nxt;
  logic signed [35:0]  prod;
  logic signed [31:0]  mag;

  // step select: square, Horner steps, final scale with clamp and sign
  always_comb begin
    q_nxt = d;
    prod  = '0;
    mag   = '0;
    if (STEP == 0) begin
      prod    = mul_q30(34'($signed({1'b0, d.x})), 32'($signed({1'b0, d.x})));
      q_nxt.x2 = prod[30:0];
      q_nxt.p  = SIN_COEF[4];
    end else if (STEP < SIN_STEPS - 1) begin
      prod    = mul_q30(34'(d.p), 32'($signed({1'b0, d.x2})));
      q_nxt.p = SIN_COEF[COEF_IDX] + prod[31:0];
    end else begin
      prod = mul_q30(34'($signed({1'b0, d.x})), d.p);
      if (prod < 36'sd0)                           mag = '0;
      else if (prod > 36'($signed({1'b0, Q30_ONE}))) mag = 32'($signed({1'b0, Q30_ONE}));
      else                                         mag = prod[31:0];
      q_nxt.p = d.neg ? -mag : mag;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (en) q_r <= q_nxt;
  end

endmodule

/* rtl/core/cpvf_sin_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpvf_sin_lane
// Row of sine cells turning a binary angle into its sine in Q30.
// ----------------------------------------------------------------------------
module cpvf_sin_lane #(
  parameter int ANGLE_BITS = cpvf_pkg::ANGLE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [ANGLE_BITS-1:0]   ang,
  output logic signed [31:0]      sin_q30
);
  import cpvf_pkg::*;

  logic [31:0] turn;
  sin_lane_t   head;
  sin_lane_t   link [SIN_STEPS+1];

  // quadrant fold: top two bits pick mirror and sign
  always_comb begin
    turn      = {ang, {(32-ANGLE_BITS){1'b0}}};
    head      = '0;
    head.neg  = turn[31];
    head.x    = turn[30] ? (Q30_ONE - {1'b0, turn[29:0]}) : {1'b0, turn[29:0]};
  end

  assign link[0] = head;

  // cell chain
  for (genvar i = 0; i < SIN_STEPS; i++) begin : g_cell
    cpvf_sin_cell #(.STEP(i)) u_cell (
      .clk (clk),
      .en  (en),
      .d   (link[i]),
      .q_r (link[i+1])
    );
  end

  assign sin_q30 = link[SIN_STEPS].p;

endmodule

/* rtl/core/cabin_position_to_view_frame_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cabin_position_to_view_frame_top
// Places the jetway cabin and expresses it in the viewer's heading frame.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle; the whole pipeline stalls together
// when the output register is full and not taken.
// The six-cell sine rows and the two multiply stages after them set the depth.
// Reset (synchronous, active low) clears all valid bits; no pending results.
module cabin_position_to_view_frame_top #(
  parameter int ANGLE_BITS = cpvf_pkg::ANGLE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  cpvf_in_if.sink    in_chan,
  cpvf_out_if.source out_chan
);
  import cpvf_pkg::*;

  localparam int DEPTH = SIN_STEPS + 2;
  localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

  logic                  en;
  logic [DEPTH-1:0]      vld_r;
  logic                  out_valid_r;
  logic [ANGLE_BITS-1:0] ang_sum;
  logic [ANGLE_BITS-1:0] ang_swing_sin;
  logic [ANGLE_BITS-1:0] ang_head_cos;
  logic signed [31:0]    sw_cos, sw_sin, hd_cos, hd_sin;
  side_t                 side_in;
  side_t                 side_r [SIN_STEPS];

  logic signed [33:0]    dx_r, dz_r, dy1_r;
  logic signed [31:0]    ch_r, sh_r;
  logic signed [35:0]    a_r, b_r, c_r, e_r;
  logic signed [33:0]    dy2_r;
  logic signed [35:0]    reach_cos, reach_sin;
  logic [31:0]           right_r, up_r, back_r;

  // pipeline advances unless the output holds an untaken result
  assign en            = !out_valid_r || out_chan.ready;
  assign in_chan.ready = en;

  // angle setup
  assign ang_sum       = in_chan.jetway_rotation + in_chan.stand_heading;
  assign ang_swing_sin = ang_sum - QUARTER;
  assign ang_head_cos  = in_chan.eye_heading + QUARTER;

  cpvf_sin_lane #(.ANGLE_BITS(ANGLE_BITS)) u_sw_cos (
    .clk(clk), .en(en), .ang(ang_sum), .sin_q30(sw_cos));
  cpvf_sin_lane #(.ANGLE_BITS(ANGLE_BITS)) u_sw_sin (
    .clk(clk), .en(en), .ang(ang_swing_sin), .sin_q30(sw_sin));
  cpvf_sin_lane #(.ANGLE_BITS(ANGLE_BITS)) u_hd_cos (
    .clk(clk), .en(en), .ang(ang_head_cos), .sin_q30(hd_cos));
  cpvf_sin_lane #(.ANGLE_BITS(ANGLE_BITS)) u_hd_sin (
    .clk(clk), .en(en), .ang(in_chan.eye_heading), .sin_q30(hd_sin));

  // position differences carried beside the sine rows
  always_comb begin
    side_in.dx0   = 33'(in_chan.jetway_x) - 33'(in_chan.eye_x);
    side_in.dz0   = 33'(in_chan.jetway_z) - 33'(in_chan.eye_z);
    side_in.dy    = 34'(in_chan.jetway_y) + 34'(in_chan.cabin_height)
                    - 34'(in_chan.eye_y);
    side_in.reach = 17'(in_chan.tunnel_extent) + 17'(in_chan.cabin_offset);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_in;
      for (int i = 1; i < SIN_STEPS; i++) side_r[i] <= side_r[i-1];
    end
  end

  // cabin placement at reach along the swing angle
  assign reach_cos = mul_q30(34'($signed({1'b0, side_r[SIN_STEPS-1].reach})), sw_cos);
  assign reach_sin = mul_q30(34'($signed({1'b0, side_r[SIN_STEPS-1].reach})), sw_sin);

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r  <= 34'(side_r[SIN_STEPS-1].dx0) + 34'(reach_cos);
      dz_r  <= 34'(side_r[SIN_STEPS-1].dz0) + 34'(reach_sin);
      dy1_r <= side_r[SIN_STEPS-1].dy;
      ch_r  <= hd_cos;
      sh_r  <= hd_sin;
    end
  end

  // rotation products
  always_ff @(posedge clk) begin
    if (en) begin
      a_r   <= mul_q30(dx_r, ch_r);
      b_r   <= mul_q30(dz_r, sh_r);
      c_r   <= mul_q30(dz_r, ch_r);
      e_r   <= mul_q30(dx_r, sh_r);
      dy2_r <= dy1_r;
    end
  end

  // sums and saturation into the output register
  always_ff @(posedge clk) begin
    if (en) begin
      right_r <= sat32(37'(a_r) + 37'(b_r));
      back_r  <= sat32(37'(c_r) - 37'(e_r));
      up_r    <= sat32(37'(dy2_r));
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[DEPTH-2:0], in_chan.valid};
      out_valid_r <= vld_r[DEPTH-1];
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.rel_right = right_r;
  assign out_chan.rel_up    = up_r;
  assign out_chan.rel_back  = back_r;

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the cabin view frame block against a bit-true model of the cabin
// placement and viewer rotation. Random gaps on both sides, a long output
// stall, a drain pause, and directed extremes ahead of random transactions.
// ----------------------------------------------------------------------------
module tb;
  import cpvf_pkg::*;

  localparam int ABITS = 16;

  typedef struct packed {
    logic signed [31:0] jx, jy, jz;
    logic [15:0]        rot, psi, ext, ofs;
    logic signed [15:0] hgt;
    logic signed [31:0] ex, ey, ez;
    logic [15:0]        hd;
  } cabin_req_t;

  typedef struct packed {
    logic signed [31:0] right, up, back;
  } view_pos_t;

  logic clk = 1'b0;
  logic rst_n;
  cpvf_in_if #(.ANGLE_BITS(ABITS)) in_chan ();
  cpvf_out_if out_chan ();

  cabin_position_to_view_frame_top #(.ANGLE_BITS(ABITS)) dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan)
  );

  cabin_req_t req_q[$];
  view_pos_t  view_q[$];
  int         n_fail = 0;
  bit         stim_done;
  bit         drain_hold;
  bit         hold_go;
  bit         out_block;

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // rounded product with a q30 factor, halves away from zero
  function automatic longint q30_mul(longint a, longint b);
    bit       neg;
    longint   ua, ub;
    longint unsigned m;
    neg = (a < 0) != (b < 0);
    ua  = a < 0 ? -a : a;
    ub  = b < 0 ? -b : b;
    m   = (longint'(ua) * longint'(ub) + (64'd1 << 29)) >> 30;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint quad_sine(longint x);
    longint coef[5];
    longint x2, p;
    coef = '{1686629713, -693598668, 85569306, -5026995, 172273};
    x2 = q30_mul(x, x);
    p = coef[4];
    for (int i = 3; i >= 0; i--) p = coef[i] + q30_mul(p, x2);
    p = q30_mul(x, p);
    if (p < 0) p = 0;
    if (p > (64'sd1 << 30)) p = 64'sd1 << 30;
    return p;
  endfunction

  function automatic longint angle_sine(logic [15:0] ang);
    logic [31:0] t;
    longint r, s;
    t = {ang, 16'd0};
    r = longint'(t[29:0]);
    s = t[30] ? quad_sine((64'sd1 << 30) - r) : quad_sine(r);
    return t[31] ? -s : s;
  endfunction

  function automatic longint angle_cosine(logic [15:0] ang);
    return angle_sine(ang + 16'h4000);
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // expected cabin position in the viewer's frame
  function automatic view_pos_t cabin_in_view(cabin_req_t r);
    logic [15:0] swing;
    longint      reach, dx, dy, dz, ch, sh;
    view_pos_t   v;
    swing = r.rot + r.psi - 16'h4000;
    reach = longint'(r.ext) + longint'(r.ofs);
    dx = longint'(r.jx) + q30_mul(reach, angle_cosine(swing)) - longint'(r.ex);
    dy = longint'(r.jy) + longint'(r.hgt) - longint'(r.ey);
    dz = longint'(r.jz) + q30_mul(reach, angle_sine(swing)) - longint'(r.ez);
    ch = angle_cosine(r.hd);
    sh = angle_sine(r.hd);
    v.right = clamp32(q30_mul(dx, ch) + q30_mul(dz, sh));
    v.up    = clamp32(dy);
    v.back  = clamp32(q30_mul(dz, ch) - q30_mul(dx, sh));
    return v;
  endfunction

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 40000)) - 20000);
      default: return $urandom;
    endcase
  endfunction

  function automatic cabin_req_t rand_req();
    cabin_req_t r;
    r.jx = pick32(); r.jy = pick32(); r.jz = pick32();
    r.ex = pick32(); r.ey = pick32(); r.ez = pick32();
    r.rot = $urandom; r.psi = $urandom; r.hd = $urandom;
    r.ext = $urandom; r.ofs = $urandom; r.hgt = $urandom;
    // mostly nearby viewer so the rotation stays in range
    if ($urandom_range(0, 3) != 0) begin
      r.ex = r.jx + 32'($signed($urandom_range(0, 200000)) - 100000);
      r.ez = r.jz + 32'($signed($urandom_range(0, 200000)) - 100000);
    end
    return r;
  endfunction

  // stimulus
  initial begin
    cabin_req_t r;
    stim_done = 1'b0;
    drain_hold = 1'b0;
    hold_go = 1'b0;
    // directed: extremes and special angles
    for (int i = 0; i < 20; i++) begin
      r = '0;
      case (i % 5)
        0: r = '0;
        1: r = '1;
        2: begin
          r.jx = 32'h7FFF_FFFF; r.jz = 32'h7FFF_FFFF; r.jy = 32'h7FFF_FFFF;
          r.ex = 32'h8000_0000; r.ez = 32'h8000_0000; r.ey = 32'h8000_0000;
          r.hgt = 16'sh7FFF; r.ext = 16'hFFFF; r.ofs = 16'hFFFF;
        end
        3: begin
          r.jx = 32'h8000_0000; r.jz = 32'h8000_0000; r.jy = 32'h8000_0000;
          r.ex = 32'h7FFF_FFFF; r.ez = 32'h7FFF_FFFF; r.ey = 32'h7FFF_FFFF;
          r.hgt = 16'sh8000;
        end
        default: begin
          r.ext = 16'h1234; r.ofs = 16'h0F00;
        end
      endcase
      r.rot = 16'(i * 16'h4000); r.psi = 16'hC000 + 16'(i * 16'h2000);
      r.hd = 16'(i * 16'h3000) ^ 16'(i[0] ? 16'h0001 : 16'hFFFF);
      req_q.push_back(r);
    end
    wait (rst_n === 1'b1);
    for (int i = 0; i < 950; i++) begin
      if (i == 300) begin
        // pause the sender until everything has drained
        wait (req_q.size() == 0 && !in_chan.valid);
        drain_hold = 1'b1;
        wait (view_q.size() == 0);
        drain_hold = 1'b0;
      end
      if (i == 600) hold_go = 1'b1;
      req_q.push_back(rand_req());
    end
    stim_done = 1'b1;
  end

  // reset
  initial begin
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // long receiver hold-off, counted in cycles
  initial begin
    out_block = 1'b0;
    wait (hold_go);
    @(posedge clk);
    out_block = 1'b1;
    repeat (60) @(posedge clk);
    out_block = 1'b0;
  end

  // driver: offers the next item after a random gap
  int  in_gap;
  bit  in_took;
  always @(posedge clk) begin
    in_took <= rst_n && in_chan.valid && in_chan.ready;
    if (rst_n && in_chan.valid && in_chan.ready)
      view_q.push_back(cabin_in_view(cabin_req_t'({in_chan.jetway_x,
        in_chan.jetway_y, in_chan.jetway_z, in_chan.jetway_rotation,
        in_chan.stand_heading, in_chan.tunnel_extent, in_chan.cabin_offset,
        in_chan.cabin_height, in_chan.eye_x, in_chan.eye_y, in_chan.eye_z,
        in_chan.eye_heading})));
  end

  always @(negedge clk) begin
    cabin_req_t r;
    if (!rst_n) begin
      in_gap <= 0;
      in_chan.valid <= 1'b0;
    end else if (!in_chan.valid || in_took) begin
      if (in_took && in_gap == 0 && req_q.size() != 0 && !drain_hold) begin
        // keep valid high, new payload
      end
      if (in_gap > 0 || req_q.size() == 0 || drain_hold) begin
        in_chan.valid <= 1'b0;
        if (in_gap > 0) in_gap <= in_gap - 1;
      end else begin
        r = req_q.pop_front();
        in_chan.valid <= 1'b1;
        in_chan.jetway_x <= r.jx; in_chan.jetway_y <= r.jy;
        in_chan.jetway_z <= r.jz; in_chan.jetway_rotation <= r.rot;
        in_chan.stand_heading <= r.psi; in_chan.tunnel_extent <= r.ext;
        in_chan.cabin_offset <= r.ofs; in_chan.cabin_height <= r.hgt;
        in_chan.eye_x <= r.ex; in_chan.eye_y <= r.ey; in_chan.eye_z <= r.ez;
        in_chan.eye_heading <= r.hd;
        in_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
      end
    end
  end

  // monitor: compares each result transaction with the oldest expectation
  int out_gap;
  always @(posedge clk) begin
    view_pos_t e;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (view_q.size() == 0) begin
        $error("result with nothing expected");
        n_fail++;
      end else begin
        e = view_q.pop_front();
        if (out_chan.rel_right !== e.right) begin
          $error("rel_right exp %0d got %0d", e.right, out_chan.rel_right);
          n_fail++;
        end
        if (out_chan.rel_up !== e.up) begin
          $error("rel_up exp %0d got %0d", e.up, out_chan.rel_up);
          n_fail++;
        end
        if (out_chan.rel_back !== e.back) begin
          $error("rel_back exp %0d got %0d", e.back, out_chan.rel_back);
          n_fail++;
        end
      end
    end
  end

  // receiver stalls, including one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_gap <= 0;
      out_chan.ready <= 1'b0;
    end else if (out_block) begin
      out_chan.ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_chan.ready <= 1'b0;
      out_gap <= out_gap - 1;
    end else begin
      out_chan.ready <= 1'b1;
      if (out_chan.valid && out_chan.ready && $urandom_range(0, 3) == 0)
        out_gap <= $urandom_range(0, 18);
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    wait (req_q.size() == 0 && !in_chan.valid && view_q.size() == 0);
    repeat (30) @(posedge clk);
    if (n_fail == 0 && view_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // timeout
  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule

/* filelist.f */
rtl/core/cpvf_pkg.sv
rtl/core/cpvf_ifs.sv
rtl/core/cpvf_sin_cell.sv
rtl/core/cpvf_sin_lane.sv
rtl/core/cabin_position_to_view_frame_top.sv
bench/tb.sv
